// ===== design/pvm_pkg.sv =====
// Shared types and constants for the PCM voice mixer.
`timescale 1ns / 1ps
package pvm_pkg;

	localparam int POS_W             = 24;
	localparam int WORD_W            = 64;
	localparam int SRC_W             = 4;
	localparam int SAMPLES_PER_FRAME = 8;
	localparam int LANES             = WORD_W / 8;

	localparam logic KIND_FETCH = 1'b0;
	localparam logic KIND_MIX   = 1'b1;

	localparam logic [SRC_W-1:0] SRC_MUSIC = '0;

	typedef enum logic [1:0] {
		FN_START  = 2'd0,
		FN_PLAN   = 2'd1,
		FN_ADD    = 2'd2,
		FN_FINISH = 2'd3
	} pvm_func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUSIC,
		ST_WALK,
		ST_FIN
	} pvm_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic take;    // input transfer this cycle
		logic music;   // issue the music request
		logic step;    // process the current voice slot
		logic finish;  // issue the mixed frame
	} pvm_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;    // output register can load this cycle
		logic voice_emit;  // current slot produces a request
		logic walk_last;   // current slot is the final one
	} pvm_status_t;

endpackage

// ===== design/pvm_ctrl.sv =====
// Controller state machine for the PCM voice mixer.
`timescale 1ns / 1ps
module pvm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         func,
	output logic               in_ready,
	input  pvm_pkg::pvm_status_t st,
	output pvm_pkg::pvm_cmd_t    cmd
);
	import pvm_pkg::*;

	pvm_state_t state_q;
	pvm_state_t state_d;
	logic       take;

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && func == FN_PLAN) begin
					state_d = ST_MUSIC;
				end else if (take && func == FN_FINISH) begin
					state_d = ST_FIN;
				end
			end
			ST_MUSIC: begin
				if (st.out_free) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if ((!st.voice_emit || st.out_free) && st.walk_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = take;
			end
			ST_MUSIC: cmd.music  = st.out_free;
			// A slot that makes no request never waits on the output.
			ST_WALK:  cmd.step   = !st.voice_emit || st.out_free;
			ST_FIN:   cmd.finish = st.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/pvm_datapath.sv =====
// Voice table, music position, accumulator and output register of the mixer.
`timescale 1ns / 1ps
module pvm_datapath #(
	parameter int VOICES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pvm_pkg::POS_W-1:0]   cfg_data,
	input  logic [1:0]                  func,
	input  logic [2:0]                  voice_slot,
	input  logic [pvm_pkg::POS_W-1:0]   voice_length,
	input  logic [pvm_pkg::WORD_W-1:0]  sample_word,
	input  pvm_pkg::pvm_cmd_t           cmd,
	output pvm_pkg::pvm_status_t        st,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kind,
	output logic [pvm_pkg::SRC_W-1:0]   source,
	output logic [pvm_pkg::POS_W-1:0]   fetch_offset,
	output logic [pvm_pkg::WORD_W-1:0]  mixed_word,
	output logic                        last
);
	import pvm_pkg::*;

	localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

	logic [POS_W-1:0]  music_len_q;
	logic [POS_W-1:0]  music_pos_q;
	logic [WORD_W-1:0] acc_q;
	logic [VOICES-1:0] active_q;
	logic [POS_W-1:0]  pos_q [VOICES];
	logic [POS_W-1:0]  end_q [VOICES];
	logic [VIDX_W-1:0] idx_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [SRC_W-1:0]  source_q;
	logic [POS_W-1:0]  offset_q;
	logic [WORD_W-1:0] mixed_q;
	logic              last_q;

	logic [POS_W:0]    nxt [VOICES];
	logic [VOICES-1:0] emit_mask;
	logic [VOICES-1:0] above_mask;
	logic [POS_W-1:0]  music_off;
	logic [WORD_W-1:0] acc_sum;
	logic              slot_ok;
	logic              load_voice;

	// A voice stays only if its advanced position, at full width, is below its end.
	always_comb begin
		for (int j = 0; j < VOICES; j++) begin
			nxt[j]        = {1'b0, pos_q[j]} + (POS_W+1)'(SAMPLES_PER_FRAME);
			emit_mask[j]  = active_q[j] && (nxt[j] < {1'b0, end_q[j]});
			above_mask[j] = VIDX_W'(j) > idx_q;
		end
	end

	always_comb begin
		for (int b = 0; b < LANES; b++) begin
			acc_sum[b*8 +: 8] = acc_q[b*8 +: 8] + sample_word[b*8 +: 8];
		end
	end

	assign music_off  = (music_pos_q > music_len_q) ? '0 : music_pos_q;
	assign slot_ok    = {1'b0, voice_slot} < 4'(VOICES);
	assign load_voice = cmd.step && emit_mask[idx_q];

	assign st.out_free   = !out_valid_q || out_ready;
	assign st.voice_emit = emit_mask[idx_q];
	assign st.walk_last  = idx_q == VIDX_W'(VOICES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			music_len_q <= '0;
			music_pos_q <= '0;
			acc_q       <= '0;
			active_q    <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				music_len_q <= cfg_data;
			end
			if (cmd.take && func == FN_START && slot_ok) begin
				active_q[voice_slot[VIDX_W-1:0]] <= 1'b1;
			end
			if (cmd.take && func == FN_ADD) begin
				acc_q <= acc_sum;
			end else if ((cmd.take && func == FN_PLAN) || cmd.finish) begin
				acc_q <= '0;
			end
			if (cmd.music) begin
				music_pos_q <= music_off + POS_W'(2);
				idx_q       <= '0;
			end
			if (cmd.step) begin
				if (!emit_mask[idx_q]) begin
					active_q[idx_q] <= 1'b0;
				end
				if (!st.walk_last) begin
					idx_q <= idx_q + VIDX_W'(1);
				end
			end
			if (cmd.music || cmd.finish || load_voice) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Voice table; entries are only read while the slot is active.
	always_ff @(posedge clk) begin
		if (cmd.take && func == FN_START && slot_ok) begin
			pos_q[voice_slot[VIDX_W-1:0]] <= '0;
			end_q[voice_slot[VIDX_W-1:0]] <= voice_length;
		end
		if (cmd.step && active_q[idx_q]) begin
			pos_q[idx_q] <= nxt[idx_q][POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.music) begin
			kind_q   <= KIND_FETCH;
			source_q <= SRC_MUSIC;
			offset_q <= music_off;
			mixed_q  <= '0;
			last_q   <= ~|emit_mask;
		end else if (cmd.finish) begin
			kind_q   <= KIND_MIX;
			source_q <= SRC_MUSIC;
			offset_q <= '0;
			mixed_q  <= acc_q;
			last_q   <= 1'b1;
		end else if (load_voice) begin
			kind_q   <= KIND_FETCH;
			source_q <= SRC_W'(idx_q) + SRC_W'(1);
			offset_q <= pos_q[idx_q];
			mixed_q  <= '0;
			last_q   <= ~|(emit_mask & above_mask);
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign source       = source_q;
	assign fetch_offset = offset_q;
	assign mixed_word   = mixed_q;
	assign last         = last_q;

endmodule

// ===== design/pcm_voice_mixer.sv =====
// PCM voice mixer top level: music and voice fetch planning plus frame mixing.
// Usage:
//   Items arrive on the input channel (in_valid/in_ready) with func selecting
//   start voice, plan frame, add samples or finish frame. Results leave on the
//   output channel (out_valid/out_ready) through one output register.
//   Start and add items produce nothing.
//   A finish item emits the mixed word with last set.
//   A plan item emits the music request once the output register is free, then
//   visits every voice slot in order, one slot per cycle unless a slot that
//   must emit waits on the output; each slot that stays active emits a
//   request, and the final request of the plan carries last.
//   When the receiver stalls, the pending result holds in the output register
//   and the walk waits on the next slot that needs to emit; slots that emit
//   nothing keep moving. Start and add items are taken while a result waits.
//   Reset clears the music length register, the music position, the
//   accumulator and all voice active flags, and empties the output register.
//   The music length register may be written whenever the block is idle.
`timescale 1ns / 1ps
module pcm_voice_mixer #(
	parameter int VOICES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pvm_pkg::POS_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [2:0]                  voice_slot,
	input  logic [pvm_pkg::POS_W-1:0]   voice_length,
	input  logic [pvm_pkg::WORD_W-1:0]  sample_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        kind,
	output logic [pvm_pkg::SRC_W-1:0]   source,
	output logic [pvm_pkg::POS_W-1:0]   fetch_offset,
	output logic [pvm_pkg::WORD_W-1:0]  mixed_word,
	output logic                        last
);
	import pvm_pkg::*;

	pvm_cmd_t    cmd;
	pvm_status_t st;

	pvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	pvm_datapath #(
		.VOICES (VOICES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.func         (func),
		.voice_slot   (voice_slot),
		.voice_length (voice_length),
		.sample_word  (sample_word),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.source       (source),
		.fetch_offset (fetch_offset),
		.mixed_word   (mixed_word),
		.last         (last)
	);

endmodule

// ===== design/pvm_checker.sv =====
// Port-level checks for the PCM voice mixer and their binding.
`timescale 1ns / 1ps
module pvm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  func,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        kind,
	input logic [pvm_pkg::SRC_W-1:0]   source,
	input logic [pvm_pkg::POS_W-1:0]   fetch_offset,
	input logic [pvm_pkg::WORD_W-1:0]  mixed_word,
	input logic                        last
);
	import pvm_pkg::*;

	// A stalled result stays put until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mixed_word)
			&& $stable(fetch_offset) && $stable(source) && $stable(last))
		else $error("output result changed while stalled");

	// A mixed frame is always the single, final result of its item.
	a_mix_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_MIX |-> last && source == SRC_MUSIC
			&& fetch_offset == '0)
		else $error("mixed frame with bad fields");

	a_fetch_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_FETCH |-> mixed_word == '0)
		else $error("fetch request with nonzero mixed word");

	// Plan and finish items occupy the block: the input is not ready right after their transfer.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FN_PLAN || func == FN_FINISH) |=> !in_ready)
		else $error("input taken right after a plan or finish transfer");

endmodule

bind pcm_voice_mixer pvm_checker u_pvm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.func         (func),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.source       (source),
	.fetch_offset (fetch_offset),
	.mixed_word   (mixed_word),
	.last         (last)
);
